>>> rtl/core/tlapp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlapp_pkg
// Shared types, widths and constants for the two-link arm position plotter.
// ----------------------------------------------------------------------------
package tlapp_pkg;

   localparam int MV_W       = 14;
   localparam int SLOPE_W    = 16;
   localparam int OFF_W      = 10;
   localparam int LEN_W      = 14;
   localparam int ANG_W      = 32;   // degrees, 16 fraction bits
   localparam int TRIG_W     = 32;   // Q30
   localparam int POS_W      = 16;   // Q8
   localparam int EXT_W      = 17;
   localparam int SPAN_W     = 18;
   localparam int DVD_W      = 29;   // span * grid size
   localparam int QUOT_W     = 10;   // widest grid index
   localparam int STEP_W     = 4;
   localparam int STATUS_W   = 3;
   localparam int REQ_W      = 32;

   localparam int DEF_GRID_COLS = 128;
   localparam int DEF_GRID_ROWS = 64;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DROP  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CAL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PLOT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OFF   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOCAL = 3'd4;

   // register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SLOPE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELBOW_SLOPE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ELBOW_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LEN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LEN    = 3'd5;

   // angle constants, degrees Q16
   localparam logic [32:0]        FULL_TURN    = 33'd23592960;
   localparam logic [32:0]        REDUCE_BIAS  = 33'd3019898880;  // 128 turns
   localparam logic signed [25:0] FULL_Q16     = 26'sd23592960;
   localparam logic signed [25:0] HALF_Q16     = 26'sd11796480;
   localparam logic signed [25:0] QUARTER_Q16  = 26'sd5898240;
   localparam logic signed [ANG_W-1:0] HALF_ANG = 32'sd11796480;

   localparam int CORDIC_STEPS = 17;
   localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

   function automatic logic [21:0] atan_q16(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58671;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic                     done;
      logic signed [TRIG_W-1:0] cos_q30;
      logic signed [TRIG_W-1:0] sin_q30;
   } cordic_res_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

endpackage

>>> rtl/core/tlapp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlapp_cordic
// Iterative sine/cosine: turn reduction, quadrant fold, 17 rotation steps.
// ----------------------------------------------------------------------------
module tlapp_cordic import tlapp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ANG_W-1:0] angle,
   output cordic_res_type          res
);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_RED  = 2'd1;
   localparam logic [1:0] C_FOLD = 2'd2;
   localparam logic [1:0] C_ROT  = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [4:0]        step_ff, step_in;
   logic [32:0]       red_ff, red_in;
   logic signed [25:0] r_ff, r_in;
   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;

   logic [32:0]        sub;
   logic signed [25:0] r0;
   logic signed [32:0] dx, dy;
   logic signed [25:0] at;
   logic signed [32:0] xo, yo;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      red_in   = red_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      sub      = FULL_TURN << step_ff;
      r0       = $signed({1'b0, red_ff[24:0]});
      dx       = x_ff >>> step_ff;
      dy       = y_ff >>> step_ff;
      at       = $signed({4'b0, atan_q16(step_ff)});
      case (phase_ff)
         C_IDLE: begin
            if (start) begin
               red_in   = {angle[ANG_W-1], angle} + REDUCE_BIAS;
               step_in  = 5'd7;
               phase_in = C_RED;
            end
         end
         C_RED: begin
            if (red_ff >= sub) begin
               red_in = red_ff - sub;
            end
            if (step_ff == 5'd0) begin
               phase_in = C_FOLD;
            end else begin
               step_in = step_ff - 5'd1;
            end
         end
         C_FOLD: begin
            if (r0 >= HALF_Q16) begin
               r0 = r0 - FULL_Q16;
            end
            neg_in = 1'b0;
            if (r0 > QUARTER_Q16) begin
               r0     = r0 - HALF_Q16;
               neg_in = 1'b1;
            end else if (r0 < -QUARTER_Q16) begin
               r0     = r0 + HALF_Q16;
               neg_in = 1'b1;
            end
            r_in     = r0;
            x_in     = CORDIC_K;
            y_in     = '0;
            step_in  = 5'd0;
            phase_in = C_ROT;
         end
         C_ROT: begin
            if (r_ff >= 0) begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               r_in = r_ff - at;
            end else begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               r_in = r_ff + at;
            end
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               done_in  = 1'b1;
               phase_in = C_IDLE;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         default: phase_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      red_ff  <= red_in;
      r_ff    <= r_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      neg_ff  <= neg_in;
   end

   assign xo          = neg_ff ? -x_ff : x_ff;
   assign yo          = neg_ff ? -y_ff : y_ff;
   assign res.done    = done_ff;
   assign res.cos_q30 = xo[TRIG_W-1:0];
   assign res.sin_q30 = yo[TRIG_W-1:0];

endmodule

>>> rtl/core/tlapp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlapp_divider
// Restoring divider, one quotient bit a cycle, quotient known to fit steps.
// ----------------------------------------------------------------------------
module tlapp_divider import tlapp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [SPAN_W-1:0] divisor,
   input  logic [STEP_W-1:0] steps,
   output div_res_type       res
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SPAN_W:0]   rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [SPAN_W:0]   trial;
   logic [DVD_W-1:0]  high;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      high    = dividend >> steps;
      trial   = {rem_ff[SPAN_W-1:0], dvd_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = high[SPAN_W:0];
         dvd_in  = dividend << (5'(DVD_W) - {1'b0, steps});
         q_in    = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
   end

   assign res.done = done_ff;
   assign res.quot = q_ff;

endmodule

>>> rtl/core/two_link_arm_position_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_arm_position_plotter
// Joint voltages to tip position, extent calibration and grid plotting.
// ----------------------------------------------------------------------------
// Path, accept to rsp_tvalid: a dropped sample goes straight to the output
//   register; calibrate and plot samples first form the tip position.
// The shared CORDIC sets most of it: per angle 8 reduce steps, 1 fold step and
//   17 rotate steps, two angles a word; each divide runs one step per quotient bit.
// Flow control: one word at a time; req_tready is low from accept until the
//   result is loaded.
// Reset: synchronous, active high; state, output valid and configuration registers
//   return to their reset values, and the calibration extents clear to zero, not yet valid.
// ----------------------------------------------------------------------------
module two_link_arm_position_plotter import tlapp_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   localparam int COL_W    = $clog2(GRID_COLS),
   localparam int ROW_W    = $clog2(GRID_ROWS),
   localparam int RSP_RAW  = 2 * POS_W + COL_W + ROW_W,
   localparam int RSP_W    = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // sample words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // base_mv[13:0], elbow_mv[27:14]
   input  logic                  req_tuser,   // plot_mode
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // x_pos, y_pos, column, grid_row
   output logic [STATUS_W-1:0]   rsp_tuser,   // status
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MB   = 5'd1;   // base slope * mv
   localparam logic [4:0] S_ME   = 5'd2;   // elbow slope * mv
   localparam logic [4:0] S_ANG  = 5'd3;   // form elbow angle, start base CORDIC
   localparam logic [4:0] S_CB   = 5'd4;
   localparam logic [4:0] S_CE   = 5'd5;
   localparam logic [4:0] S_M1   = 5'd6;   // L1*cos base
   localparam logic [4:0] S_M2   = 5'd7;   // L2*cos elbow
   localparam logic [4:0] S_M3   = 5'd8;   // x done, L1*sin base
   localparam logic [4:0] S_M4   = 5'd9;   // L2*sin elbow
   localparam logic [4:0] S_M5   = 5'd10;  // y done, decide
   localparam logic [4:0] S_MN   = 5'd11;  // offset * grid size
   localparam logic [4:0] S_CK   = 5'd12;  // range check
   localparam logic [4:0] S_DV   = 5'd13;  // wait on divider
   localparam logic [4:0] S_FIN  = 5'd14;
   localparam logic [4:0] S_OUT  = 5'd15;

   localparam logic signed [49:0] ROUND_HALF = 50'sd536870912;

   // configuration
   logic [SLOPE_W-1:0]      base_slope_ff, elbow_slope_ff;
   logic signed [OFF_W-1:0] base_offset_ff, elbow_offset_ff;
   logic [LEN_W-1:0]        upper_len_ff, lower_len_ff;

   // calibration state
   logic signed [EXT_W-1:0] x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic signed [EXT_W-1:0] y_min_ff, y_min_in, y_max_ff, y_max_in;
   logic                    ext_valid_ff, ext_valid_in;

   // datapath
   logic [4:0]               state_ff, state_in;
   logic signed [MV_W-1:0]   bmv_ff, bmv_in, emv_ff, emv_in;
   logic                     plot_ff, plot_in;
   logic signed [49:0]       prod_ff, prod_in, acc_ff, acc_in;
   logic signed [ANG_W-1:0]  ba_ff, ba_in, aa_ff, aa_in;
   logic signed [TRIG_W-1:0] cb_ff, cb_in, sb_ff, sb_in, ce_ff, ce_in, se_ff, se_in;
   logic signed [POS_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic                     axis_ff, axis_in;    // 0 column, 1 row
   logic                     on_ff, on_in;
   logic [STATUS_W-1:0]      status_ff, status_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COL_W-1:0]         rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]         rsp_row_ff, rsp_row_in;

   // shared multiplier operands
   logic signed [17:0]       mul_a;
   logic signed [31:0]       mul_b;

   logic                     req_fire;
   logic signed [SPAN_W-1:0] num_sel, span_sel;
   logic signed [EXT_W-1:0]  xe, ye;
   logic signed [ANG_W-1:0]  boff_q16, eoff_q16;

   logic                     cor_start;
   logic signed [ANG_W-1:0]  cor_angle;
   cordic_res_type           cor_res;
   logic                     div_start;
   logic [STEP_W-1:0]        div_steps;
   div_res_type              div_res;

   // rounds Q30 sum to Q8 with floor shift, then saturates
   function automatic logic signed [POS_W-1:0] to_q8(input logic signed [49:0] s);
      logic signed [49:0] t;
      logic signed [19:0] v;
      logic signed [POS_W-1:0] r;
      t = s + ROUND_HALF;
      v = 20'(t >>> 30);
      if (v > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign boff_q16 = {{(ANG_W - OFF_W - 16){base_offset_ff[OFF_W-1]}}, base_offset_ff, 16'b0};
   assign eoff_q16 = {{(ANG_W - OFF_W - 16){elbow_offset_ff[OFF_W-1]}}, elbow_offset_ff, 16'b0};
   assign xe       = EXT_W'(x_ff);
   assign ye       = EXT_W'(y_ff);
   assign num_sel  = axis_ff ? (SPAN_W'(ye) - SPAN_W'(y_min_ff))
                             : (SPAN_W'(xe) - SPAN_W'(x_min_ff));
   assign span_sel = axis_ff ? (SPAN_W'(y_max_ff) - SPAN_W'(y_min_ff))
                             : (SPAN_W'(x_max_ff) - SPAN_W'(x_min_ff));

   assign prod_in   = 50'(mul_a * mul_b);
   assign cor_angle = (state_ff == S_ANG) ? ba_ff : aa_ff;
   assign div_steps = axis_ff ? STEP_W'(ROW_W) : STEP_W'(COL_W);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bmv_in       = bmv_ff;
      emv_in       = emv_ff;
      plot_in      = plot_ff;
      acc_in       = acc_ff;
      ba_in        = ba_ff;
      aa_in        = aa_ff;
      cb_in        = cb_ff;
      sb_in        = sb_ff;
      ce_in        = ce_ff;
      se_in        = se_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      axis_in      = axis_ff;
      on_in        = on_ff;
      status_in    = status_ff;
      x_min_in     = x_min_ff;
      x_max_in     = x_max_ff;
      y_min_in     = y_min_ff;
      y_max_in     = y_max_ff;
      ext_valid_in = ext_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      cor_start    = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               bmv_in  = req_tdata[MV_W-1:0];
               emv_in  = req_tdata[2*MV_W-1:MV_W];
               plot_in = req_tuser;
               col_in  = '0;
               row_in  = '0;
               if ($signed(req_tdata[MV_W-1:0]) <= 0 ||
                   $signed(req_tdata[2*MV_W-1:MV_W]) <= 0) begin
                  status_in = ST_DROP;
                  x_in      = '0;
                  y_in      = '0;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_MB;
               end
            end
         end
         S_MB: begin
            mul_a    = {2'b0, base_slope_ff};
            mul_b    = 32'(bmv_ff);
            state_in = S_ME;
         end
         S_ME: begin
            ba_in    = prod_ff[ANG_W-1:0] + boff_q16;
            mul_a    = {2'b0, elbow_slope_ff};
            mul_b    = 32'(emv_ff);
            state_in = S_ANG;
         end
         S_ANG: begin
            // absolute elbow = elbow + base - 180 degrees
            aa_in     = prod_ff[ANG_W-1:0] + eoff_q16 + ba_ff - HALF_ANG;
            cor_start = 1'b1;
            state_in  = S_CB;
         end
         S_CB: begin
            if (cor_res.done) begin
               cb_in     = cor_res.cos_q30;
               sb_in     = cor_res.sin_q30;
               cor_start = 1'b1;
               state_in  = S_CE;
            end
         end
         S_CE: begin
            if (cor_res.done) begin
               ce_in    = cor_res.cos_q30;
               se_in    = cor_res.sin_q30;
               state_in = S_M1;
            end
         end
         S_M1: begin
            mul_a    = {4'b0, upper_len_ff};
            mul_b    = cb_ff;
            state_in = S_M2;
         end
         S_M2: begin
            acc_in   = prod_ff;
            mul_a    = {4'b0, lower_len_ff};
            mul_b    = ce_ff;
            state_in = S_M3;
         end
         S_M3: begin
            x_in     = to_q8(acc_ff + prod_ff);
            mul_a    = {4'b0, upper_len_ff};
            mul_b    = sb_ff;
            state_in = S_M4;
         end
         S_M4: begin
            acc_in   = prod_ff;
            mul_a    = {4'b0, lower_len_ff};
            mul_b    = se_ff;
            state_in = S_M5;
         end
         S_M5: begin
            y_in = to_q8(acc_ff + prod_ff);
            if (!plot_ff) begin
               // calibrate: first sample seeds, later ones widen
               if (!ext_valid_ff) begin
                  x_min_in = xe;
                  x_max_in = xe;
                  y_min_in = EXT_W'(y_in);
                  y_max_in = EXT_W'(y_in);
                  ext_valid_in = 1'b1;
               end else begin
                  if (xe < x_min_ff) begin
                     x_min_in = xe;
                  end else if (xe > x_max_ff) begin
                     x_max_in = xe;
                  end
                  if (EXT_W'(y_in) < y_min_ff) begin
                     y_min_in = EXT_W'(y_in);
                  end else if (EXT_W'(y_in) > y_max_ff) begin
                     y_max_in = EXT_W'(y_in);
                  end
               end
               status_in = ST_CAL;
               state_in  = S_OUT;
            end else if (!ext_valid_ff || x_max_ff == x_min_ff || y_max_ff == y_min_ff) begin
               status_in = ST_NOCAL;
               state_in  = S_OUT;
            end else begin
               axis_in  = 1'b0;
               on_in    = 1'b1;
               state_in = S_MN;
            end
         end
         S_MN: begin
            mul_a    = num_sel;
            mul_b    = axis_ff ? 32'(GRID_ROWS) : 32'(GRID_COLS);
            state_in = S_CK;
         end
         S_CK: begin
            // negative offset truncates to zero while its magnitude is short of span
            if (prod_ff < 0) begin
               if (-prod_ff >= 50'(span_sel)) begin
                  on_in = 1'b0;
               end
               axis_in  = 1'b1;
               state_in = axis_ff ? S_FIN : S_MN;
            end else if (num_sel >= span_sel) begin
               on_in    = 1'b0;
               axis_in  = 1'b1;
               state_in = axis_ff ? S_FIN : S_MN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DV;
            end
         end
         S_DV: begin
            if (div_res.done) begin
               if (axis_ff) begin
                  row_in   = div_res.quot[ROW_W-1:0];
                  state_in = S_FIN;
               end else begin
                  col_in   = div_res.quot[COL_W-1:0];
                  axis_in  = 1'b1;
                  state_in = S_MN;
               end
            end
         end
         S_FIN: begin
            status_in = on_ff ? ST_PLOT : ST_OFF;
            if (!on_ff) begin
               col_in = '0;
               row_in = '0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_x_in      = x_ff;
               rsp_y_in      = y_ff;
               rsp_col_in    = col_ff;
               rsp_row_in    = row_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         ext_valid_ff    <= 1'b0;
         x_min_ff        <= '0;
         x_max_ff        <= '0;
         y_min_ff        <= '0;
         y_max_ff        <= '0;
         base_slope_ff   <= 16'd3932;
         base_offset_ff  <= -10'sd150;
         elbow_slope_ff  <= 16'd3932;
         elbow_offset_ff <= 10'sd30;
         upper_len_ff    <= 14'd2176;
         lower_len_ff    <= 14'd2176;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ext_valid_ff <= ext_valid_in;
         x_min_ff     <= x_min_in;
         x_max_ff     <= x_max_in;
         y_min_ff     <= y_min_in;
         y_max_ff     <= y_max_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_SLOPE:   base_slope_ff   <= csr_data;
               CSR_BASE_OFFSET:  base_offset_ff  <= csr_data[OFF_W-1:0];
               CSR_ELBOW_SLOPE:  elbow_slope_ff  <= csr_data;
               CSR_ELBOW_OFFSET: elbow_offset_ff <= csr_data[OFF_W-1:0];
               CSR_UPPER_LEN:    upper_len_ff    <= csr_data[LEN_W-1:0];
               CSR_LOWER_LEN:    lower_len_ff    <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      bmv_ff        <= bmv_in;
      emv_ff        <= emv_in;
      plot_ff       <= plot_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      ba_ff         <= ba_in;
      aa_ff         <= aa_in;
      cb_ff         <= cb_in;
      sb_ff         <= sb_in;
      ce_ff         <= ce_in;
      se_ff         <= se_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      axis_ff       <= axis_in;
      on_ff         <= on_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

   tlapp_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .angle (cor_angle),
      .res   (cor_res)
   );

   tlapp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[DVD_W-1:0]),
      .divisor  (span_sel),
      .steps    (div_steps),
      .res      (div_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'({rsp_row_ff, rsp_col_ff, rsp_y_ff, rsp_x_ff});

   // ---------------------------------------------------------------- checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second word taken while busy");

   a_extents_ordered: assert property (@(posedge clock) disable iff (reset)
      ext_valid_ff |-> (x_min_ff <= x_max_ff && y_min_ff <= y_max_ff))
      else $error("calibration extents out of order");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_DROP) |->
         (rsp_x_ff == 0 && rsp_y_ff == 0 && rsp_col_ff == 0 && rsp_row_ff == 0))
      else $error("dropped sample carries data");

   a_grid_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_PLOT) |->
         (32'(rsp_col_ff) < GRID_COLS && 32'(rsp_row_ff) < GRID_ROWS))
      else $error("plotted point beyond grid");

endmodule

>>> sim/arm_position_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_position_checker
// Watches the sample, result and register channels of the arm position
// plotter, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module arm_position_checker import tlapp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [47:0]           rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    pending
);

   localparam longint COLS = 128;
   localparam longint ROWS = 64;
   localparam longint TURN = 23592960;
   localparam longint HALF = 11796480;
   localparam longint QUART = 5898240;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic signed [15:0]  x_pos;
      logic signed [15:0]  y_pos;
      logic [6:0]          column;
      logic [5:0]          grid_row;
   } tip_result_type;

   const longint arc_step [17] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

   // register copies
   longint             base_gain, elbow_gain, upper_len, lower_len;
   logic signed [9:0]  base_bias, elbow_bias;
   // calibration extents
   longint             x_lo, x_hi, y_lo, y_hi;
   bit                 span_known;

   tip_result_type     expected_tips [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // CORDIC in Q30 with half-turn fold, floor shifts
   function automatic void joint_sincos(input longint ang, output longint c, output longint s);
      longint r, x, y, nx;
      bit     flip;
      r = ang % TURN;
      if (r < 0) r += TURN;
      if (r >= HALF) r -= TURN;
      flip = 0;
      if (r > QUART) begin
         r -= HALF;
         flip = 1;
      end else if (r < -QUART) begin
         r += HALF;
         flip = 1;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < 17; i++) begin
         if (r >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            r -= arc_step[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            r += arc_step[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint q8_clamp(input longint p);
      longint v;
      v = (p + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic tip_result_type predict_tip(input longint bmv, input longint emv,
                                                  input bit plot);
      tip_result_type t;
      longint         ba, aa, cb, sb, ce, se, x, y, col, row;
      t = '{ST_DROP, 0, 0, 0, 0};
      if (bmv <= 0 || emv <= 0) return t;
      ba = base_gain * bmv + longint'(base_bias) * 65536;
      aa = elbow_gain * emv + longint'(elbow_bias) * 65536 + ba - HALF;
      joint_sincos(ba, cb, sb);
      joint_sincos(aa, ce, se);
      x = q8_clamp(upper_len * cb + lower_len * ce);
      y = q8_clamp(upper_len * sb + lower_len * se);
      t.x_pos = x[15:0];
      t.y_pos = y[15:0];
      if (!plot) begin
         if (!span_known) begin
            x_lo = x; x_hi = x; y_lo = y; y_hi = y;
            span_known = 1;
         end else begin
            if (x < x_lo) x_lo = x;
            else if (x > x_hi) x_hi = x;
            if (y < y_lo) y_lo = y;
            else if (y > y_hi) y_hi = y;
         end
         t.status = ST_CAL;
      end else if (!span_known || x_hi == x_lo || y_hi == y_lo) begin
         t.status = ST_NOCAL;
      end else begin
         col = (x - x_lo) * COLS / (x_hi - x_lo);
         row = (y - y_lo) * ROWS / (y_hi - y_lo);
         if (col >= 0 && col < COLS && row >= 0 && row < ROWS) begin
            t.status   = ST_PLOT;
            t.column   = col[6:0];
            t.grid_row = row[5:0];
         end else begin
            t.status = ST_OFF;
         end
      end
      return t;
   endfunction

   assign pending = expected_tips.size();

   initial errors = 0;

   always @(posedge clock) begin
      tip_result_type want;
      if (reset) begin
         base_gain  = 3932;
         base_bias  = -10'sd150;
         elbow_gain = 3932;
         elbow_bias = 10'sd30;
         upper_len  = 2176;
         lower_len  = 2176;
         x_lo = 0; x_hi = 0; y_lo = 0; y_hi = 0;
         span_known = 0;
         expected_tips.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_SLOPE:   base_gain  = csr_data;
               CSR_BASE_OFFSET:  base_bias  = csr_data[9:0];
               CSR_ELBOW_SLOPE:  elbow_gain = csr_data;
               CSR_ELBOW_OFFSET: elbow_bias = csr_data[9:0];
               CSR_UPPER_LEN:    upper_len  = csr_data[13:0];
               CSR_LOWER_LEN:    lower_len  = csr_data[13:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_tips.push_back(predict_tip($signed(req_tdata[13:0]),
                                                $signed(req_tdata[27:14]), req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tips.size() == 0) begin
               report_mismatch("unexpected word, status", rsp_tuser, -1);
            end else begin
               want = expected_tips.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[15:0] !== want.x_pos)
                  report_mismatch("x_pos", $signed(rsp_tdata[15:0]), want.x_pos);
               if (rsp_tdata[31:16] !== want.y_pos)
                  report_mismatch("y_pos", $signed(rsp_tdata[31:16]), want.y_pos);
               if (rsp_tdata[38:32] !== want.column)
                  report_mismatch("column", rsp_tdata[38:32], want.column);
               if (rsp_tdata[44:39] !== want.grid_row)
                  report_mismatch("grid_row", rsp_tdata[44:39], want.grid_row);
            end
         end
      end
   end

endmodule

>>> sim/two_link_arm_position_plotter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_arm_position_plotter_test
// Drives joint samples and register settings into the plotter; a checker
// beside the block predicts each result word and counts mismatches.
// ----------------------------------------------------------------------------
module two_link_arm_position_plotter_test;
   import tlapp_pkg::*;

   localparam int PHASES     = 10;
   localparam int PER_PHASE  = 112;
   localparam int DRAIN      = 120;
   localparam int CYCLE_CAP  = 1000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [47:0]           rsp_tdata;   // x_pos, y_pos, column, grid_row
   logic [STATUS_W-1:0]   rsp_tuser;   // status
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int errors, pending;
   int samples_sent = 0;
   int cycles = 0;
   bit calm = 0;           // no idling near the end
   bit hold_rsp = 0;       // asks for the long output stall
   bit hold_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   two_link_arm_position_plotter i_dut (.*);

   arm_position_checker i_checker (.*);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold-off while the sender keeps
   // offering so the block backs up onto req_tready
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_done = 1;
            rsp_tready <= 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // one sample word; valid stays up across back-to-back words
   task automatic send_sample(input int bmv, input int emv, input bit plot);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'b0, 14'(emv), 14'(bmv)};
      req_tuser  <= plot;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= 16'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   // block must be empty before any register write
   task automatic drain_block;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic int live_mv;
      return $urandom_range(1, 5000);
   endfunction

   function automatic int any_mv;
      return int'($urandom_range(0, 10000)) - 5000;
   endfunction

   initial begin
      int bs, bo, es, eo, ul, ll, n_cal;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: plot before calibration, drops, zero span, extremes
      send_sample(1000, 1000, 1);
      send_sample(0, 500, 0);
      send_sample(500, 0, 1);
      send_sample(-5000, -5000, 0);
      send_sample(-1, 3000, 0);
      send_sample(2500, 2500, 0);
      send_sample(2500, 2500, 1);
      send_sample(1, 1, 0);
      send_sample(5000, 5000, 0);
      send_sample(5000, 1, 0);
      send_sample(1, 5000, 0);
      send_sample(2500, 2500, 1);
      send_sample(3000, 1200, 1);
      send_sample(1, 1, 1);
      send_sample(5000, 5000, 1);
      send_sample(4096, 4095, 1);
      send_sample(2047, 1024, 1);
      send_sample(5000, -4096, 1);

      for (int p = 0; p < PHASES; p++) begin
         drain_block();
         case (p)
            0: begin bs = 3932;  bo = -150; es = 3932;  eo = 30;   ul = 2176;  ll = 2176;  end
            1: begin bs = 0;     bo = -360; es = 65535; eo = 360;  ul = 16383; ll = 16383; end
            2: begin bs = 65535; bo = 360;  es = 0;     eo = -360; ul = 0;     ll = 0;     end
            default: begin
               bs = $urandom_range(0, 65535);
               bo = int'($urandom_range(0, 720)) - 360;
               es = $urandom_range(0, 65535);
               eo = int'($urandom_range(0, 720)) - 360;
               ul = $urandom_range(0, 16383);
               ll = $urandom_range(0, 16383);
            end
         endcase
         write_reg(CSR_BASE_SLOPE, bs);
         write_reg(CSR_BASE_OFFSET, bo);
         write_reg(CSR_ELBOW_SLOPE, es);
         write_reg(CSR_ELBOW_OFFSET, eo);
         write_reg(CSR_UPPER_LEN, ul);
         write_reg(CSR_LOWER_LEN, ll);
         // indexes past the last register must be ignored
         write_reg(CSR_LOWER_LEN + 3'd1, $urandom_range(0, 65535));
         write_reg(CSR_LOWER_LEN + 3'd2, $urandom_range(0, 65535));
         csr_valid <= 0;
         @(posedge clock);

         if (p == 5) hold_rsp = 1;
         if (p == PHASES - 1) calm = 1;
         // a calibration sweep then plotting, with some noise mixed in
         n_cal = $urandom_range(10, 30);
         for (int i = 0; i < PER_PHASE; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_sample(any_mv(), any_mv(), $urandom_range(0, 1));
            else
               send_sample(live_mv(), live_mv(), i >= n_cal);
         end
      end

      drain_block();
      $display("covered %0d samples over %0d register settings,", samples_sent, PHASES);
      $display("with drops, calibration, plotting and a long output stall");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
